// ===== rtl/ppt_pkg.sv =====
`timescale 1ns / 1ps

package ppt_pkg;

	localparam int MAX_NODES_DEF   = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int OP_W      = 2;
	localparam int NODE_W    = 3;
	localparam int KIND_W    = 2;
	localparam int NCOUNT_W  = 4;
	localparam int THR_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_INC   = 2'd1,
		OP_BUILD = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic [KIND_W-1:0] KIND_OK      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;

	localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 4'd8;
	localparam logic [THR_W-1:0]    THRESHOLD_RST  = 16'd100;

endpackage

// ===== rtl/ppt_ram.sv =====
`timescale 1ns / 1ps

module ppt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pairwise_preference_tally_top.sv =====
`timescale 1ns / 1ps
// Clear, unknown-node and unused opcodes: the ack word is registered from state ST_ACK,
// which waits on output stall; the next request word is taken only back in ST_IDLE.
// Increment: read-modify-write; read on accept, written back with the ack in ST_INC.
// Build: each pair i<j steps through ST_RDA, ST_RDB, ST_SUB and ST_CMP, using the
// single RAM read port and the shared subtract/compare unit; output stalls hold it.
// Reset: all counters read as zero via per-entry valid bits, node_count 8, threshold 100.
module pairwise_preference_tally_top #(
	parameter int MAX_NODES   = ppt_pkg::MAX_NODES_DEF,
	parameter int COUNT_WIDTH = ppt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [ppt_pkg::OP_W-1:0]       opcode,
	input  logic [ppt_pkg::NODE_W-1:0]     winner_node,
	input  logic [ppt_pkg::NODE_W-1:0]     loser_node,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [ppt_pkg::KIND_W-1:0]     kind,
	output logic [ppt_pkg::NODE_W-1:0]     edge_from,
	output logic [ppt_pkg::NODE_W-1:0]     edge_to,
	output logic                           last
);

	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = ((COUNT_WIDTH > ppt_pkg::THR_W) ? COUNT_WIDTH : ppt_pkg::THR_W) + 2;
	localparam int NW    = ppt_pkg::NODE_W;
	localparam int CW    = ppt_pkg::NCOUNT_W;
	localparam logic [CW-1:0] MAX_N = CW'(MAX_NODES);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACK  = 8'b0000_0010,
		ST_INC  = 8'b0000_0100,
		ST_RDA  = 8'b0000_1000,
		ST_RDB  = 8'b0001_0000,
		ST_SUB  = 8'b0010_0000,
		ST_CMP  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] row,
		input logic [NW-1:0] col);
		cell_addr = AW'(32'(row) * 32'(MAX_NODES) + 32'(col));
	endfunction

	state_t state_q, state_d;

	logic [CW-1:0]                node_count_q;
	logic [ppt_pkg::THR_W-1:0]    thr_q;
	logic [CW-1:0]                n_act;
	logic [DEPTH-1:0]             vld_q;
	logic                         rd_vld_s1;
	logic [ppt_pkg::KIND_W-1:0]   kind_q;
	logic                         clr_q;
	logic [AW-1:0]                wr_addr_q;
	logic [NW-1:0]                i_q, j_q;
	logic [COUNT_WIDTH-1:0]       a_q;
	logic signed [XW-1:0]         diff_q;

	logic                         accept, known, emit_ok;
	logic                         ram_re, ram_we;
	logic [AW-1:0]                ram_raddr;
	logic [COUNT_WIDTH-1:0]       ram_rdata, rd_val, inc_val;
	logic signed [XW-1:0]         thr_x, diff_d;
	logic                         gt, lt, more_j, more_i;

	logic                         emit;
	logic [ppt_pkg::KIND_W-1:0]   emit_kind;
	logic [NW-1:0]                emit_from, emit_to;
	logic                         emit_last;
	logic                         start_build, do_clear, advance;

	logic                         rsp_valid_q;
	logic [ppt_pkg::KIND_W-1:0]   kind_s1;
	logic [NW-1:0]                from_s1, to_s1;
	logic                         last_s1;

	assign n_act     = (node_count_q > MAX_N) ? MAX_N : node_count_q;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign known     = ({1'b0, winner_node} < n_act) && ({1'b0, loser_node} < n_act);
	assign emit_ok   = !rsp_valid_q || !rsp_stall;

	// Entries never written since reset or the last clear read as zero.
	assign rd_val  = rd_vld_s1 ? ram_rdata : '0;
	assign inc_val = (rd_val == '1) ? rd_val : rd_val + COUNT_WIDTH'(1);

	assign thr_x  = $signed({{(XW - ppt_pkg::THR_W){1'b0}}, thr_q});
	assign diff_d = $signed({{(XW - COUNT_WIDTH){1'b0}}, a_q})
		- $signed({{(XW - COUNT_WIDTH){1'b0}}, rd_val});
	assign gt     = diff_q > thr_x;
	assign lt     = diff_q < -thr_x;
	assign more_j = ({1'b0, j_q} + CW'(1)) < n_act;
	assign more_i = ({1'b0, i_q} + CW'(2)) < n_act;

	ppt_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_counts (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr_q),
		.wdata(inc_val),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		ram_re      = 1'b0;
		ram_raddr   = cell_addr(i_q, j_q);
		ram_we      = 1'b0;
		emit        = 1'b0;
		emit_kind   = ppt_pkg::KIND_OK;
		emit_from   = '0;
		emit_to     = '0;
		emit_last   = 1'b1;
		start_build = 1'b0;
		do_clear    = 1'b0;
		advance     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						ppt_pkg::OP_INC: begin
							if (known) begin
								ram_re    = 1'b1;
								ram_raddr = cell_addr(winner_node, loser_node);
								state_d   = ST_INC;
							end else begin
								state_d = ST_ACK;
							end
						end
						ppt_pkg::OP_BUILD: begin
							start_build = 1'b1;
							state_d     = (n_act < CW'(2)) ? ST_DONE : ST_RDA;
						end
						default: state_d = ST_ACK;
					endcase
				end
			end
			ST_ACK: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_kind = kind_q;
					do_clear  = clr_q;
					state_d   = ST_IDLE;
				end
			end
			ST_INC: begin
				if (emit_ok) begin
					ram_we  = 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RDA: begin
				ram_re    = 1'b1;
				ram_raddr = cell_addr(i_q, j_q);
				state_d   = ST_RDB;
			end
			ST_RDB: begin
				ram_re    = 1'b1;
				ram_raddr = cell_addr(j_q, i_q);
				state_d   = ST_SUB;
			end
			ST_SUB: state_d = ST_CMP;
			ST_CMP: begin
				if (gt || lt) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_kind = ppt_pkg::KIND_EDGE;
						emit_from = gt ? i_q : j_q;
						emit_to   = gt ? j_q : i_q;
						emit_last = 1'b0;
						advance   = 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance) begin
					state_d = (more_j || more_i) ? ST_RDA : ST_DONE;
				end
			end
			ST_DONE: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_kind = ppt_pkg::KIND_DONE;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= ppt_pkg::NODE_COUNT_RST;
			thr_q        <= ppt_pkg::THRESHOLD_RST;
			vld_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ppt_pkg::REG_NODE_COUNT: node_count_q <= cfg_wdata[CW-1:0];
					ppt_pkg::REG_THRESHOLD:  thr_q <= cfg_wdata[ppt_pkg::THR_W-1:0];
					default: ;
				endcase
			end
			if (do_clear) begin
				vld_q <= '0;
			end else if (ram_we) begin
				vld_q[wr_addr_q] <= 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_vld_s1 <= vld_q[ram_raddr];
		end
		if (accept) begin
			clr_q     <= (opcode == ppt_pkg::OP_CLEAR);
			kind_q    <= (opcode == ppt_pkg::OP_INC) ? ppt_pkg::KIND_UNKNOWN : ppt_pkg::KIND_OK;
			wr_addr_q <= cell_addr(winner_node, loser_node);
		end
		if (start_build) begin
			i_q <= '0;
			j_q <= NW'(1);
		end else if (advance) begin
			if (more_j) begin
				j_q <= j_q + NW'(1);
			end else begin
				i_q <= i_q + NW'(1);
				j_q <= i_q + NW'(2);
			end
		end
		if (state_q == ST_RDB) begin
			a_q <= rd_val;
		end
		if (state_q == ST_SUB) begin
			diff_q <= diff_d;
		end
		if (emit) begin
			kind_s1 <= emit_kind;
			from_s1 <= emit_from;
			to_s1   <= emit_to;
			last_s1 <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind      = kind_s1;
	assign edge_from = from_s1;
	assign edge_to   = to_s1;
	assign last      = last_s1;

	// The pair being scanned is always above the diagonal and inside the active range.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDA) |-> ((i_q < j_q) && ({1'b0, j_q} < n_act)))
		else $error("build scan pair out of order or range");

	// An emitted edge never connects a node to itself.
	a_edge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (emit_kind == ppt_pkg::KIND_EDGE)) |=> (rsp_valid && (edge_from != edge_to)))
		else $error("edge word with equal endpoints");

	// A clear leaves every counter reading as zero.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(do_clear) |=> (vld_q == '0))
		else $error("valid bits survived a clear");

	// Counters are written only by an increment of known nodes.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_INC) && ($past(state_q) == ST_IDLE || $past(state_q) == ST_INC)))
		else $error("counter write outside an increment");

endmodule

// ===== tb/sv/pref_tally_checker.sv =====
`timescale 1ns / 1ps

module pref_tally_checker
	import ppt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [OP_W-1:0]      opcode,
	input  logic [NODE_W-1:0]    winner_node,
	input  logic [NODE_W-1:0]    loser_node,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [NODE_W-1:0]    edge_from,
	input  logic [NODE_W-1:0]    edge_to,
	input  logic                 last,
	output int                   errors,
	output int                   outstanding
);

	localparam int SHOWN_MAX = 40;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic              last;
	} tally_word_t;

	logic [COUNT_WIDTH_DEF-1:0] tally [0:MAX_NODES_DEF*MAX_NODES_DEF-1];
	logic [NCOUNT_W-1:0]        node_cnt;
	logic [THR_W-1:0]           thr;
	tally_word_t                expected_words [$];

	task automatic report(input string what);
		errors++;
		if (errors <= SHOWN_MAX)
			$display("[%0t] tally check: %s", $realtime, what);
	endtask

	task automatic expect_word(input logic [KIND_W-1:0] k, input int src, input int dst,
			input logic lst);
		tally_word_t w;
		w.kind = k;
		w.src  = src[NODE_W-1:0];
		w.dst  = dst[NODE_W-1:0];
		w.last = lst;
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic predict_tally(input opcode_t op, input logic [NODE_W-1:0] w,
			input logic [NODE_W-1:0] l);
		int n;
		int i;
		int j;
		int a;
		int b;
		int d;
		int t;
		int idx;
		n = (node_cnt > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_cnt);
		t = int'(thr);
		case (op)
			OP_CLEAR: begin
				foreach (tally[e])
					tally[e] = '0;
				expect_word(KIND_OK, 0, 0, 1'b1);
			end
			OP_INC: begin
				if (w >= n || l >= n) begin
					expect_word(KIND_UNKNOWN, 0, 0, 1'b1);
				end else begin
					idx = w * MAX_NODES_DEF + l;
					if (tally[idx] != '1)
						tally[idx] = tally[idx] + 1'b1;
					expect_word(KIND_OK, 0, 0, 1'b1);
				end
			end
			OP_BUILD: begin
				for (i = 0; i < n; i++) begin
					for (j = i + 1; j < n; j++) begin
						a = int'(tally[i * MAX_NODES_DEF + j]);
						b = int'(tally[j * MAX_NODES_DEF + i]);
						d = a - b;
						if (d > t)
							expect_word(KIND_EDGE, i, j, 1'b0);
						else if (d < -t)
							expect_word(KIND_EDGE, j, i, 1'b0);
					end
				end
				expect_word(KIND_DONE, 0, 0, 1'b1);
			end
			default: begin
				expect_word(KIND_OK, 0, 0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		tally_word_t want;
		if (!arst_n) begin
			node_cnt = NODE_COUNT_RST;
			thr      = THRESHOLD_RST;
			foreach (tally[e])
				tally[e] = '0;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NODE_COUNT)
					node_cnt = cfg_wdata[NCOUNT_W-1:0];
				else if (cfg_index == REG_THRESHOLD)
					thr = cfg_wdata[THR_W-1:0];
			end
			// A result word can never stem from the request taken at the same edge,
			// so the result side is handled first.
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					report($sformatf("unexpected word kind=%0d from=%0d to=%0d last=%0d",
						kind, edge_from, edge_to, last));
				end else begin
					want = expected_words.pop_front();
					if (kind !== want.kind)
						report($sformatf("kind got %0d want %0d", kind, want.kind));
					if (edge_from !== want.src)
						report($sformatf("edge_from got %0d want %0d", edge_from, want.src));
					if (edge_to !== want.dst)
						report($sformatf("edge_to got %0d want %0d", edge_to, want.dst));
					if (last !== want.last)
						report($sformatf("last got %0d want %0d", last, want.last));
				end
			end
			if (req_valid && !req_stall)
				predict_tally(opcode_t'(opcode), winner_node, loser_node);
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ppt_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_WORDS   = 450;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_wdata   = '0;
	logic                 req_valid   = 1'b0;
	logic                 req_stall;
	logic [OP_W-1:0]      opcode      = '0;
	logic [NODE_W-1:0]    winner_node = '0;
	logic [NODE_W-1:0]    loser_node  = '0;
	logic                 rsp_valid;
	logic                 rsp_stall   = 1'b0;
	logic [KIND_W-1:0]    kind;
	logic [NODE_W-1:0]    edge_from;
	logic [NODE_W-1:0]    edge_to;
	logic                 last;

	int errors;
	int outstanding;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pairwise_preference_tally_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .winner_node(winner_node), .loser_node(loser_node),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.kind(kind), .edge_from(edge_from), .edge_to(edge_to), .last(last)
	);

	pref_tally_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .winner_node(winner_node), .loser_node(loser_node),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.kind(kind), .edge_from(edge_from), .edge_to(edge_to), .last(last),
		.errors(errors), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("pairwise_preference_tally_top: mismatch");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// The result side holds stall for a random number of cycles before each word.
	always begin
		int hold;
		hold = idle_on ? $urandom_range(0, 7) : 0;
		if (hold != 0) begin
			rsp_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
		rsp_stall <= 1'b0;
		do @(posedge clk); while (rsp_valid !== 1'b1);
	end

	task automatic send_word(input opcode_t op, input logic [NODE_W-1:0] w,
			input logic [NODE_W-1:0] l);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		opcode      <= op;
		winner_node <= w;
		loser_node  <= l;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [NCOUNT_W-1:0] nc, input logic [THR_W-1:0] thr);
		settle();
		write_reg(REG_NODE_COUNT, CFG_W'(nc));
		write_reg(REG_THRESHOLD, CFG_W'(thr));
	endtask

	// Most words are increments inside the active range, many on one hot pair so
	// that builds find edges; the rest is out-of-range noise and other opcodes.
	task automatic random_word(input int lim, input logic [NODE_W-1:0] hot_w,
			input logic [NODE_W-1:0] hot_l);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_word(OP_CLEAR, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)));
		else if (r < 13)
			send_word(OP_BUILD, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)));
		else if (r < 17)
			send_word(OP_NONE, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)));
		else if (r < 30)
			send_word(OP_INC, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)));
		else if (r < 60)
			send_word(OP_INC, hot_w, hot_l);
		else
			send_word(OP_INC, NODE_W'($urandom_range(0, lim)),
				NODE_W'($urandom_range(0, lim)));
	endtask

	initial begin
		int sent;
		int k;
		int r;
		int lim;
		int phase_len;
		logic [NCOUNT_W-1:0] nc;
		logic [THR_W-1:0]    thr;
		logic [NODE_W-1:0]   hot_w;
		logic [NODE_W-1:0]   hot_l;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset settings.
		send_word(OP_BUILD, 0, 0);
		send_word(OP_NONE, 7, 7);
		send_word(OP_INC, 7, 0);
		send_word(OP_INC, 0, 7);
		send_word(OP_INC, 3, 3);
		send_word(OP_INC, 7, 7);
		send_word(OP_INC, 2, 5);
		send_word(OP_INC, 6, 1);
		configure(4'd8, 16'd0);
		send_word(OP_BUILD, 0, 0);
		configure(4'd4, 16'd0);
		send_word(OP_INC, 5, 1);
		send_word(OP_INC, 1, 4);
		send_word(OP_INC, 3, 2);
		send_word(OP_BUILD, 0, 0);
		configure(4'd0, 16'd0);
		send_word(OP_INC, 0, 0);
		send_word(OP_BUILD, 0, 0);
		configure(4'd1, 16'd0);
		send_word(OP_INC, 0, 0);
		send_word(OP_BUILD, 0, 0);
		// A count above the maximum acts as the full node set; older counts survive.
		configure(4'd15, 16'd0);
		send_word(OP_BUILD, 0, 0);
		send_word(OP_CLEAR, 0, 0);
		send_word(OP_BUILD, 0, 0);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 9);
			if (r < 8)
				nc = NCOUNT_W'($urandom_range(2, 8));
			else if (r == 8)
				nc = NCOUNT_W'($urandom_range(0, 1));
			else
				nc = NCOUNT_W'($urandom_range(9, 15));
			r = $urandom_range(0, 9);
			if (r < 6)
				thr = THR_W'($urandom_range(0, 3));
			else if (r == 6)
				thr = '0;
			else if (r == 7)
				thr = '1;
			else
				thr = THR_W'($urandom);
			configure(nc, thr);
			idle_on = ($urandom_range(0, 3) != 0);
			lim = (nc > MAX_NODES_DEF) ? MAX_NODES_DEF - 1 : ((nc >= 1) ? int'(nc) - 1 : 7);
			hot_w = NODE_W'($urandom_range(0, lim));
			hot_l = NODE_W'($urandom_range(0, lim));
			phase_len = $urandom_range(20, 60);
			for (k = 0; k < phase_len; k++) begin
				random_word(lim, hot_w, hot_l);
				sent++;
				if ($urandom_range(0, 49) == 0)
					settle();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("pairwise_preference_tally_top: match");
		else
			$display("pairwise_preference_tally_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ppt_pkg.sv
rtl/ppt_ram.sv
rtl/pairwise_preference_tally_top.sv
tb/sv/pref_tally_checker.sv
tb/sv/testbench.sv
